// ===== design/spmq_pkg.sv =====
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types and codes of the strict priority multi-queue scheduler.
// ----------------------------------------------------------------------------
package spmq_pkg;

  localparam int NumClasses = 6;
  localparam int ClsW       = 3;
  localparam int IdPortW    = 16;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_POP    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_ADDED     = 3'd0,
    STAT_REMOVED   = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_POPPED    = 3'd3,
    STAT_ALL_EMPTY = 3'd4,
    STAT_FULL      = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [ClsW-1:0]    job_class;
    logic [IdPortW-1:0] job_id;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [IdPortW-1:0] out_id;
    logic [ClsW-1:0]    out_class;
  } rsp_t;

  // per-queue operation
  typedef struct packed {
    logic add;     // write id at tail
    logic rotate;  // shift toward head, old head goes to tail
    logic drop;    // shift toward head, old head is lost
  } row_cmd_t;

endpackage

// ===== design/spmq_cell.sv =====
// ----------------------------------------------------------------------------
// spmq_cell
// One queue slot: loads a new entry or takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module spmq_cell #(
  parameter int W = 16
) (
  input  logic         clk_i,
  input  logic         shift_i,
  input  logic         wr_i,
  input  logic [W-1:0] wr_data_i,
  input  logic [W-1:0] next_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      data_q <= wr_data_i;
    end else if (shift_i) begin
      data_q <= next_i;
    end
  end

  assign q_o = data_q;

endmodule

// ===== design/spmq_row.sv =====
// ----------------------------------------------------------------------------
// spmq_row
// One FIFO queue built as a chain of cells, head in cell zero, with its count.
// ----------------------------------------------------------------------------
module spmq_row #(
  parameter int DEPTH = 16,
  parameter int W     = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  spmq_pkg::row_cmd_t         cmd_i,
  input  logic [W-1:0]               id_i,
  output logic [W-1:0]               head_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int IdxW = $clog2(DEPTH);

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] tail_pos;
  logic [IdxW-1:0] wr_idx;
  logic [W-1:0]    wr_data;
  logic [W-1:0]    cell_q [DEPTH];
  logic            shift, wr;

  assign shift    = cmd_i.rotate | cmd_i.drop;
  assign wr       = cmd_i.add | cmd_i.rotate;
  // add writes just past the last entry, rotate refills the last entry
  assign tail_pos = cmd_i.add ? count_q : count_q - CntW'(1);
  assign wr_idx   = tail_pos[IdxW-1:0];
  assign wr_data  = cmd_i.add ? id_i : cell_q[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] next;
    if (i == DEPTH - 1) begin : g_last
      assign next = cell_q[i];
    end else begin : g_mid
      assign next = cell_q[i+1];
    end
    spmq_cell #(
      .W(W)
    ) u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .wr_i     (wr && (wr_idx == IdxW'(i))),
      .wr_data_i(wr_data),
      .next_i   (next),
      .q_o      (cell_q[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.add) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.drop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o  = cell_q[0];
  assign count_o = count_q;

endmodule

// ===== design/strict_priority_multi_queue.sv =====
// ----------------------------------------------------------------------------
// strict_priority_multi_queue
// Six job FIFOs with add, remove-by-id and strict priority pop.
// ----------------------------------------------------------------------------
// A command beat is taken at a rising edge with start high and busy low;
// req_i carries command, job_class and job_id. Each command gives exactly
// one result beat on rsp_o, marked by rsp_valid_o for a single cycle; the
// receiver takes it in that cycle and cannot stall it.
// Add and pop give their result in the cycle after the command beat and busy
// stays low, so a command can be taken every cycle. Remove walks its queue
// through the cell chain, one entry per cycle, by rotating the queue once
// around and dropping the first match: busy stays high while it steps once per
// entry of the queue's fill count (up to QUEUE_DEPTH), and the result shows
// after the last step. A remove on an empty queue or a class above five gives
// its result in the cycle after the command beat without raising busy. The
// rotation through the cells sets the remove time.
// Reset clears all fill counts and the result strobe; slot contents are not
// cleared and are never read beyond a queue's fill count.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  spmq_pkg::req_t req_i,
  output logic           rsp_valid_o,
  output spmq_pkg::rsp_t rsp_o
);

  localparam int IdW  = (ID_WIDTH < spmq_pkg::IdPortW) ? ID_WIDTH : spmq_pkg::IdPortW;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int NQ   = spmq_pkg::NumClasses;
  localparam int ClsW = spmq_pkg::ClsW;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_SEARCH = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    step_q, step_d;
  logic               found_q, found_d;
  logic [ClsW-1:0]    cls_q, cls_d;
  logic [IdW-1:0]     id_q, id_d;
  logic               rsp_valid_q, rsp_valid_d;
  spmq_pkg::rsp_t     rsp_q, rsp_d;

  spmq_pkg::row_cmd_t row_cmd [NQ];
  logic [IdW-1:0]     row_head [NQ];
  logic [CntW-1:0]    row_cnt [NQ];
  logic [IdW-1:0]     row_id;

  logic               cls_ok;
  logic [CntW-1:0]    sel_cnt;
  logic               pop_any;
  logic [ClsW-1:0]    pop_cls;
  logic [IdW-1:0]     pop_head;
  logic [IdW-1:0]     srch_head;
  logic               hit;
  logic [IdW-1:0]     req_id;

  assign req_id = req_i.job_id[IdW-1:0];
  assign row_id = req_id;

  for (genvar k = 0; k < NQ; k++) begin : g_row
    spmq_row #(
      .DEPTH(QUEUE_DEPTH),
      .W    (IdW)
    ) u_row (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (row_cmd[k]),
      .id_i   (row_id),
      .head_o (row_head[k]),
      .count_o(row_cnt[k])
    );
  end

  // class lookups and the priority pick
  always_comb begin
    cls_ok    = 1'b0;
    sel_cnt   = '0;
    pop_any   = 1'b0;
    pop_cls   = '0;
    pop_head  = '0;
    srch_head = '0;
    for (int k = 0; k < NQ; k++) begin
      if (req_i.job_class == ClsW'(k)) begin
        cls_ok  = 1'b1;
        sel_cnt = row_cnt[k];
      end
      if (cls_q == ClsW'(k)) begin
        srch_head = row_head[k];
      end
    end
    // descending so the lowest non-empty class wins
    for (int k = NQ - 1; k >= 0; k--) begin
      if (row_cnt[k] != '0) begin
        pop_any  = 1'b1;
        pop_cls  = ClsW'(k);
        pop_head = row_head[k];
      end
    end
  end

  assign hit = !found_q && (srch_head == id_q);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    found_d     = found_q;
    cls_d       = cls_q;
    id_d        = id_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    for (int k = 0; k < NQ; k++) begin
      row_cmd[k] = '0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          rsp_d = '0;
          priority if (req_i.command == spmq_pkg::CMD_ADD) begin
            rsp_valid_d = 1'b1;
            if (cls_ok && (sel_cnt != CntW'(QUEUE_DEPTH))) begin
              for (int k = 0; k < NQ; k++) begin
                row_cmd[k].add = (req_i.job_class == ClsW'(k));
              end
              rsp_d.status = spmq_pkg::STAT_ADDED;
            end else begin
              rsp_d.status = spmq_pkg::STAT_FULL;
            end
          end else if (req_i.command == spmq_pkg::CMD_REMOVE) begin
            if (cls_ok && (sel_cnt != '0)) begin
              state_d = S_SEARCH;
              step_d  = sel_cnt;
              found_d = 1'b0;
              cls_d   = req_i.job_class;
              id_d    = req_id;
            end else begin
              rsp_valid_d  = 1'b1;
              rsp_d.status = spmq_pkg::STAT_NOT_FOUND;
            end
          end else begin
            // pop, and the unused command code behaves the same
            rsp_valid_d = 1'b1;
            if (pop_any) begin
              for (int k = 0; k < NQ; k++) begin
                row_cmd[k].drop = (pop_cls == ClsW'(k));
              end
              rsp_d.status    = spmq_pkg::STAT_POPPED;
              rsp_d.out_id    = spmq_pkg::IdPortW'(pop_head);
              rsp_d.out_class = pop_cls;
            end else begin
              rsp_d.status = spmq_pkg::STAT_ALL_EMPTY;
            end
          end
        end
      end
      S_SEARCH: begin
        // head leaves, returns at the tail unless it is the first match
        for (int k = 0; k < NQ; k++) begin
          if (cls_q == ClsW'(k)) begin
            row_cmd[k].drop   = hit;
            row_cmd[k].rotate = !hit;
          end
        end
        found_d = found_q | hit;
        step_d  = step_q - CntW'(1);
        if (step_q == CntW'(1)) begin
          state_d      = S_IDLE;
          rsp_valid_d  = 1'b1;
          rsp_d        = '0;
          rsp_d.status = found_d ? spmq_pkg::STAT_REMOVED : spmq_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      found_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      found_q     <= found_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
    id_q  <= id_d;
    rsp_q <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef ASSERT_OFF
  a_fast_cmd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.command != spmq_pkg::CMD_REMOVE)) |=> rsp_valid_o)
    else $error("add or pop beat gave no result in the next cycle");

  a_search_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (step_q != '0))
    else $error("search running with no steps left");

  a_search_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> !rsp_valid_q)
    else $error("result strobe during an ongoing search");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status != spmq_pkg::STAT_POPPED)) |->
      ((rsp_o.out_id == '0) && (rsp_o.out_class == '0)))
    else $error("non-pop result carries id or class");
`endif

endmodule

// ===== dv/strict_priority_multi_queue_tb.sv =====
// ----------------------------------------------------------------------------
// strict_priority_multi_queue_tb
// Self-checking bench for the six-queue strict priority job scheduler. A
// scoreboard keeps its own copy of the six queues, works out the result of
// every accepted command and compares it field by field with each result
// beat. A short directed run covers the corner cases, then phases of
// fill-heavy, drain-heavy and mixed random commands push the queues to full
// and back to empty, with random gaps between command beats.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumClasses = spmq_pkg::NumClasses;
  localparam int ClsW = spmq_pkg::ClsW;
  localparam int IdPortW = spmq_pkg::IdPortW;
  localparam int QDepth = 16;
  localparam int IdW = 16;
  localparam logic [IdPortW-1:0] IdMask = IdPortW'((64'd1 << IdW) - 1);
  // the unused command code behaves as a pop
  localparam logic [1:0] CmdPopAlias = 2'd3;
  localparam int RandomCount = 700;
  localparam int PhaseLen = 40;
  localparam int MaxReported = 10;

  class spmq_scoreboard;
    spmq_pkg::rsp_t     expected_q[$];
    logic [IdPortW-1:0] slots[NumClasses][QDepth];
    int unsigned        fill[NumClasses];
    int unsigned        failures;

    function new();
      failures = 0;
      for (int c = 0; c < NumClasses; c++) begin
        fill[c] = 0;
      end
    endfunction

    function int unsigned count(int unsigned cls);
      return fill[cls];
    endfunction

    function logic [IdPortW-1:0] entry(int unsigned cls, int unsigned pos);
      return slots[cls][pos];
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // drop the entry at pos and pull the later ones toward the head
    function void close_gap(int unsigned cls, int unsigned pos);
      for (int unsigned i = pos; i + 1 < fill[cls]; i++) begin
        slots[cls][i] = slots[cls][i + 1];
      end
      fill[cls]--;
    endfunction

    function void note_command(spmq_pkg::req_t cmd);
      spmq_pkg::rsp_t     res;
      int unsigned        cls;
      logic [IdPortW-1:0] id;
      res = '0;
      cls = cmd.job_class;
      id = cmd.job_id & IdMask;
      case (cmd.command)
        spmq_pkg::CMD_ADD: begin
          if (cls >= NumClasses || fill[cls] >= QDepth) begin
            res.status = spmq_pkg::STAT_FULL;
          end else begin
            slots[cls][fill[cls]] = id;
            fill[cls]++;
            res.status = spmq_pkg::STAT_ADDED;
          end
        end
        spmq_pkg::CMD_REMOVE: begin
          res.status = spmq_pkg::STAT_NOT_FOUND;
          if (cls < NumClasses) begin
            for (int unsigned i = 0; i < fill[cls]; i++) begin
              if (slots[cls][i] == id) begin
                close_gap(cls, i);
                res.status = spmq_pkg::STAT_REMOVED;
                break;
              end
            end
          end
        end
        default: begin
          res.status = spmq_pkg::STAT_ALL_EMPTY;
          for (int unsigned q = 0; q < NumClasses; q++) begin
            if (fill[q] != 0) begin
              res.out_id = slots[q][0];
              res.out_class = ClsW'(q);
              res.status = spmq_pkg::STAT_POPPED;
              close_gap(q, 0);
              break;
            end
          end
        end
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(spmq_pkg::rsp_t got);
      spmq_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MaxReported) begin
          $display("[%0t] result beat with nothing pending: status %0d id %h class %0d",
                   $time, got.status, got.out_id, got.out_class);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.out_id !== want.out_id ||
          got.out_class !== want.out_class) begin
        failures++;
        if (failures <= MaxReported) begin
          $display({"[%0t] result differs: exp status %0d id %h class %0d, ",
                    "got status %0d id %h class %0d"},
                   $time, want.status, want.out_id, want.out_class,
                   got.status, got.out_id, got.out_class);
        end
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  spmq_pkg::req_t req_i;
  logic           rsp_valid_o;
  spmq_pkg::rsp_t rsp_o;
  spmq_scoreboard sb;
  bit             no_idle;

  strict_priority_multi_queue #(
    .QUEUE_DEPTH(QDepth),
    .ID_WIDTH   (IdW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // results first: a result beat never belongs to the command taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o) sb.check_result(rsp_o);
      if (start && !busy) sb.note_command(req_i);
    end
  end

  function automatic spmq_pkg::req_t make_command(logic [1:0] op, int unsigned cls,
                                                  logic [IdPortW-1:0] id);
    spmq_pkg::req_t r;
    r.command = op;
    r.job_class = ClsW'(cls);
    r.job_id = id;
    return r;
  endfunction

  // mode 0 fills, mode 1 drains, mode 2 mixes; most traffic goes to the focus class
  function automatic spmq_pkg::req_t random_command(int mode, int unsigned focus);
    int unsigned        r;
    int unsigned        cls;
    int unsigned        add_pct;
    int unsigned        remove_pct;
    logic [IdPortW-1:0] id;
    logic [1:0]         op;
    r = $urandom_range(0, 99);
    if (r < 5) cls = 6 + $urandom_range(0, 1);
    else if (r < 65) cls = focus;
    else cls = $urandom_range(0, NumClasses - 1);
    r = $urandom_range(0, 99);
    if (r < 40) id = IdPortW'($urandom_range(0, 7));
    else if (r < 50) id = ($urandom_range(0, 1) != 0) ? '1 : '0;
    else id = IdPortW'($urandom_range(0, 65535));
    case (mode)
      0:       begin add_pct = 80; remove_pct = 10; end
      1:       begin add_pct = 20; remove_pct = 40; end
      default: begin add_pct = 40; remove_pct = 30; end
    endcase
    r = $urandom_range(0, 99);
    if (r < add_pct) begin
      op = spmq_pkg::CMD_ADD;
    end else if (r < add_pct + remove_pct) begin
      op = spmq_pkg::CMD_REMOVE;
      // mostly remove something that is really queued
      if (cls < NumClasses && sb.count(cls) != 0 && $urandom_range(0, 99) < 70) begin
        id = sb.entry(cls, $urandom_range(0, sb.count(cls) - 1));
      end
    end else begin
      op = ($urandom_range(0, 4) == 0) ? CmdPopAlias : spmq_pkg::CMD_POP;
    end
    return make_command(op, cls, id);
  endfunction

  task automatic send_command(input spmq_pkg::req_t cmd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= cmd;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    int          mode;
    int unsigned focus;
    sb = new();
    no_idle = 1'b0;
    mode = 0;
    focus = 0;
    start <= 1'b0;
    req_i <= '0;
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner cases: empty queues, id extremes, classes six and seven,
    // duplicate ids, the spare command code
    send_command(make_command(spmq_pkg::CMD_POP, 0, '0));
    send_command(make_command(spmq_pkg::CMD_REMOVE, 0, '0));
    send_command(make_command(spmq_pkg::CMD_ADD, 0, '1));
    send_command(make_command(spmq_pkg::CMD_ADD, 5, '0));
    send_command(make_command(spmq_pkg::CMD_ADD, 6, 16'h0001));
    send_command(make_command(spmq_pkg::CMD_ADD, 7, 16'h0002));
    send_command(make_command(spmq_pkg::CMD_REMOVE, 6, '1));
    send_command(make_command(spmq_pkg::CMD_REMOVE, 7, '0));
    send_command(make_command(spmq_pkg::CMD_ADD, 2, 16'h0005));
    send_command(make_command(spmq_pkg::CMD_ADD, 2, 16'h0009));
    send_command(make_command(spmq_pkg::CMD_ADD, 2, 16'h0005));
    send_command(make_command(spmq_pkg::CMD_REMOVE, 2, 16'h0005));
    send_command(make_command(spmq_pkg::CMD_REMOVE, 2, 16'h0007));
    send_command(make_command(CmdPopAlias, 7, 16'hA5A5));
    send_command(make_command(spmq_pkg::CMD_POP, 3, 16'h5A5A));
    send_command(make_command(spmq_pkg::CMD_POP, 0, '0));
    send_command(make_command(spmq_pkg::CMD_POP, 0, '0));
    send_command(make_command(spmq_pkg::CMD_POP, 0, '0));

    for (int i = 0; i < RandomCount; i++) begin
      if (i % PhaseLen == 0) begin
        mode = $urandom_range(0, 2);
        focus = $urandom_range(0, NumClasses - 1);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      send_command(random_command(mode, focus));
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (QDepth + 4) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
